/* hw/rtl/bdrd_pkg.sv */
// Shared types, constants, calendar tables and the microcode program
// for the business-day return date block. Depends on nothing else.
`timescale 1ns / 1ps

package bdrd_pkg;

    // Field widths of the input and result words.
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int LEFT_W  = 10;
    localparam int WD_W    = 3;

    // Internal year register is one bit wider so that a late start year
    // can run past the top of the field without wrapping.
    localparam int YREG_W  = YEAR_W + 1;
    localparam int ACC_W   = 15;
    localparam int Q_W     = 12;
    localparam int Y100_W  = 7;

    localparam int MAX_VACATION_DAYS_DEF = 1023;

    localparam logic [YREG_W-1:0]  YEAR_MAX    = YREG_W'(9999);
    localparam logic [MONTH_W-1:0] MONTH_FIRST = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB   = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_LAST  = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_FIRST   = DAY_W'(1);
    localparam logic [WD_W-1:0]    WD_FRI      = WD_W'(5);
    localparam logic [WD_W-1:0]    WD_SAT      = WD_W'(6);
    localparam logic [Y100_W-1:0]  Y100_LAST   = Y100_W'(99);

    // Reciprocal constants: x / 100 for x below 2^14 and x / 7 for x below 2^15.
    localparam int RECIP100 = 5243;
    localparam int SHIFT100 = 19;
    localparam int RECIP7   = 18725;
    localparam int SHIFT7   = 17;

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [LEFT_W-1:0]  vacation_days;
    } t_in;

    typedef struct packed {
        logic [YEAR_W-1:0]  return_year;
        logic [MONTH_W-1:0] return_month;
        logic [DAY_W-1:0]   return_day;
        logic [WD_W-1:0]    return_weekday;
        logic               year_overflow;
    } t_out;

    // Datapath operations selected by the control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIVY,
        OP_SPLIT,
        OP_CLAMP,
        OP_SUM1,
        OP_SUM2,
        OP_DIV7,
        OP_REM7,
        OP_SKIP,
        OP_COUNT,
        OP_EMIT
    } t_op;

    // Jump conditions tested by the sequencer.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_IN_VALID,
        C_WEEKEND,
        C_LEFT_NZ,
        C_OUT_BUSY
    } t_cond;

    localparam int PC_W = 4;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic            inv;
        logic [PC_W-1:0] jaddr;
    } t_ctrl;

    // Status flags that the datapath hands back to the sequencer.
    typedef struct packed {
        logic weekend;
        logic left_nz;
    } t_flags;

    // Program step addresses.
    localparam logic [PC_W-1:0] PC_LOAD  = PC_W'(0);
    localparam logic [PC_W-1:0] PC_DIVY  = PC_W'(1);
    localparam logic [PC_W-1:0] PC_SPLIT = PC_W'(2);
    localparam logic [PC_W-1:0] PC_CLAMP = PC_W'(3);
    localparam logic [PC_W-1:0] PC_SUM1  = PC_W'(4);
    localparam logic [PC_W-1:0] PC_SUM2  = PC_W'(5);
    localparam logic [PC_W-1:0] PC_DIV7  = PC_W'(6);
    localparam logic [PC_W-1:0] PC_REM7  = PC_W'(7);
    localparam logic [PC_W-1:0] PC_SKIP1 = PC_W'(8);
    localparam logic [PC_W-1:0] PC_COUNT = PC_W'(9);
    localparam logic [PC_W-1:0] PC_SKIP2 = PC_W'(10);
    localparam logic [PC_W-1:0] PC_EMIT  = PC_W'(11);
    localparam logic [PC_W-1:0] PC_WRAP  = PC_W'(12);

    // The control store. A step jumps to jaddr when its condition, after
    // optional inversion, holds; otherwise it falls through to the next step.
    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl c;
        begin
            c = t_ctrl'{OP_NOP, C_ALWAYS, 1'b0, PC_LOAD};
            unique case (pc)
                PC_LOAD:  c = t_ctrl'{OP_LOAD,  C_IN_VALID, 1'b1, PC_LOAD};
                PC_DIVY:  c = t_ctrl'{OP_DIVY,  C_NEVER,    1'b0, PC_LOAD};
                PC_SPLIT: c = t_ctrl'{OP_SPLIT, C_NEVER,    1'b0, PC_LOAD};
                PC_CLAMP: c = t_ctrl'{OP_CLAMP, C_NEVER,    1'b0, PC_LOAD};
                PC_SUM1:  c = t_ctrl'{OP_SUM1,  C_NEVER,    1'b0, PC_LOAD};
                PC_SUM2:  c = t_ctrl'{OP_SUM2,  C_NEVER,    1'b0, PC_LOAD};
                PC_DIV7:  c = t_ctrl'{OP_DIV7,  C_NEVER,    1'b0, PC_LOAD};
                PC_REM7:  c = t_ctrl'{OP_REM7,  C_NEVER,    1'b0, PC_LOAD};
                PC_SKIP1: c = t_ctrl'{OP_SKIP,  C_WEEKEND,  1'b0, PC_SKIP1};
                PC_COUNT: c = t_ctrl'{OP_COUNT, C_LEFT_NZ,  1'b0, PC_COUNT};
                PC_SKIP2: c = t_ctrl'{OP_SKIP,  C_WEEKEND,  1'b0, PC_SKIP2};
                PC_EMIT:  c = t_ctrl'{OP_EMIT,  C_OUT_BUSY, 1'b0, PC_EMIT};
                PC_WRAP:  c = t_ctrl'{OP_NOP,   C_ALWAYS,   1'b0, PC_LOAD};
                default:  c = t_ctrl'{OP_NOP,   C_ALWAYS,   1'b0, PC_LOAD};
            endcase
            return c;
        end
    endfunction

    // Length of a month, with February following the leap flag.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] n;
        begin
            case (m) inside
                4'd2:                   n = leap ? DAY_W'(29) : DAY_W'(28);
                4'd4, 4'd6, 4'd9, 4'd11: n = DAY_W'(30);
                default:                n = DAY_W'(31);
            endcase
            return n;
        end
    endfunction

    // Month term of the weekday formula, (31 * shifted month) / 12, where
    // March is the first shifted month and February the last.
    function automatic logic [DAY_W-1:0] month_term(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] t;
        begin
            case (m)
                4'd1:    t = DAY_W'(28);
                4'd2:    t = DAY_W'(31);
                4'd3:    t = DAY_W'(2);
                4'd4:    t = DAY_W'(5);
                4'd5:    t = DAY_W'(7);
                4'd6:    t = DAY_W'(10);
                4'd7:    t = DAY_W'(12);
                4'd8:    t = DAY_W'(15);
                4'd9:    t = DAY_W'(18);
                4'd10:   t = DAY_W'(20);
                4'd11:   t = DAY_W'(23);
                default: t = DAY_W'(25);
            endcase
            return t;
        end
    endfunction

endpackage

/* hw/rtl/business_day_return_date.sv */
// Top level of the business-day return date block: handshakes, output
// register, sequencer and datapath. Depends on bdrd_pkg, bdrd_useq, bdrd_dpath.
//
//   Channel | Direction | Handshake          | Word
//   input   | in        | i_valid / o_ready  | i_data (start date, vacation days)
//   output  | out       | o_valid / i_ready  | o_data (return date, weekday, overflow)
//
// Words are handled one at a time: the datapath advances the date one day a
// cycle over the leading weekend, the vacation span and the trailing weekend,
// and the next input word is taken only after the last one has been emitted.
// Reset is synchronous and clears the step counter and the output valid flag.
// A finished word waits in the output register while the next input word is
// taken; the sequencer holds at its emit step while that register is still full.
`timescale 1ns / 1ps

module business_day_return_date #(
    parameter int MAX_VACATION_DAYS = bdrd_pkg::MAX_VACATION_DAYS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bdrd_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output bdrd_pkg::t_out o_data
);

    bdrd_pkg::t_ctrl  w_ctrl;
    bdrd_pkg::t_flags w_flags;
    bdrd_pkg::t_out   w_result;
    logic             w_in_acc;
    logic             w_out_busy;
    logic             w_emit;

    logic             r_out_valid;
    logic             n_out_valid;
    bdrd_pkg::t_out   r_out;
    bdrd_pkg::t_out   n_out;

    // Input handshake: a word is taken only at the load step.
    assign o_ready  = (w_ctrl.op == bdrd_pkg::OP_LOAD);
    assign w_in_acc = i_valid && o_ready;

    // Output register is busy while it holds a word not taken this cycle.
    assign w_out_busy = r_out_valid && !i_ready;
    assign w_emit     = (w_ctrl.op == bdrd_pkg::OP_EMIT) && !w_out_busy;

    bdrd_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_out_busy (w_out_busy),
        .i_flags    (w_flags),
        .o_ctrl     (w_ctrl)
    );

    bdrd_dpath #(
        .MAX_VACATION_DAYS (MAX_VACATION_DAYS)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_op      (w_ctrl.op),
        .i_load_en (w_in_acc),
        .i_data    (i_data),
        .o_flags   (w_flags),
        .o_result  (w_result)
    );

    // Output register next state.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out       = w_result;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* hw/rtl/bdrd_useq.sv */
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on bdrd_pkg.
`timescale 1ns / 1ps

module bdrd_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_busy,
    input  bdrd_pkg::t_flags i_flags,
    output bdrd_pkg::t_ctrl o_ctrl
);

    logic [bdrd_pkg::PC_W-1:0] r_pc;
    logic [bdrd_pkg::PC_W-1:0] n_pc;
    bdrd_pkg::t_ctrl           w_ctrl;
    logic                      w_cond;

    // Fetch the control word of the current step.
    assign w_ctrl = bdrd_pkg::ucode(r_pc);
    assign o_ctrl = w_ctrl;

    // Evaluate the jump condition named by the control word.
    always_comb begin
        unique case (w_ctrl.cond)
            bdrd_pkg::C_NEVER:    w_cond = 1'b0;
            bdrd_pkg::C_ALWAYS:   w_cond = 1'b1;
            bdrd_pkg::C_IN_VALID: w_cond = i_in_valid;
            bdrd_pkg::C_WEEKEND:  w_cond = i_flags.weekend;
            bdrd_pkg::C_LEFT_NZ:  w_cond = i_flags.left_nz;
            bdrd_pkg::C_OUT_BUSY: w_cond = i_out_busy;
            default:              w_cond = 1'b0;
        endcase
    end

    // Jump or fall through to the next step.
    always_comb begin
        if (w_cond ^ w_ctrl.inv) begin
            n_pc = w_ctrl.jaddr;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= bdrd_pkg::PC_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

/* hw/rtl/bdrd_dpath.sv */
// Date datapath: date, weekday, vacation counter and year-split registers,
// with the operations that the microcode selects. Depends on bdrd_pkg.
`timescale 1ns / 1ps

module bdrd_dpath #(
    parameter int MAX_VACATION_DAYS = bdrd_pkg::MAX_VACATION_DAYS_DEF
) (
    input  logic             i_clk,
    input  bdrd_pkg::t_op    i_op,
    input  logic             i_load_en,
    input  bdrd_pkg::t_in    i_data,
    output bdrd_pkg::t_flags o_flags,
    output bdrd_pkg::t_out   o_result
);

    localparam int YW = bdrd_pkg::YREG_W;
    localparam int AW = bdrd_pkg::ACC_W;
    localparam int QW = bdrd_pkg::Q_W;
    localparam int HW = bdrd_pkg::Y100_W;
    localparam int MW = bdrd_pkg::MONTH_W;
    localparam int DW = bdrd_pkg::DAY_W;
    localparam int LW = bdrd_pkg::LEFT_W;
    localparam int WW = bdrd_pkg::WD_W;
    localparam int P100_W = YW + 13;
    localparam int P7_W   = AW + 15;
    localparam logic [LW-1:0] SAT_LEFT = LW'(MAX_VACATION_DAYS);

    logic [YW-1:0] r_y,     n_y;
    logic [MW-1:0] r_m,     n_m;
    logic [DW-1:0] r_d,     n_d;
    logic [WW-1:0] r_wd,    n_wd;
    logic [LW-1:0] r_left,  n_left;
    logic [HW-1:0] r_ym100, n_ym100;
    logic [1:0]    r_yc4,   n_yc4;
    logic [QW-1:0] r_q,     n_q;
    logic [AW-1:0] r_acc,   n_acc;

    logic              w_leap;
    logic              w_weekend;
    logic [DW-1:0]     w_dim;
    logic [P100_W-1:0] w_prod100;
    logic [P7_W-1:0]   w_prod7;
    logic              w_early;
    logic [YW-1:0]     w_yy;
    logic [QW-1:0]     w_qq;

    // Day after the current date.
    logic [YW-1:0] s_y;
    logic [MW-1:0] s_m;
    logic [DW-1:0] s_d;
    logic [WW-1:0] s_wd;
    logic [HW-1:0] s_ym100;
    logic [1:0]    s_yc4;

    // Input word with out-of-range fields pulled into range.
    logic [YW-1:0] w_in_y;
    logic [MW-1:0] w_in_m;
    logic [DW-1:0] w_in_d;
    logic [LW-1:0] w_in_left;

    // Leap year from the year's remainders by 4, 100 and 400.
    assign w_leap = (r_ym100 == '0) ? (r_yc4 == 2'd0) : (r_y[1:0] == 2'd0);
    assign w_dim  = bdrd_pkg::month_days(r_m, w_leap);
    assign w_weekend = (r_wd == bdrd_pkg::WD_FRI) || (r_wd == bdrd_pkg::WD_SAT);

    // Reciprocal multipliers for the divisions by 100 and by 7.
    assign w_prod100 = P100_W'(r_y) * P100_W'(bdrd_pkg::RECIP100);
    assign w_prod7   = P7_W'(r_acc) * P7_W'(bdrd_pkg::RECIP7);

    // January and February count as months of the previous year.
    assign w_early = (r_m <= bdrd_pkg::MONTH_FEB);
    assign w_yy    = r_y - YW'(w_early);
    assign w_qq    = (w_early && (r_ym100 == '0)) ? (r_q - 1'b1) : r_q;

    // Input normalisation.
    always_comb begin
        w_in_y = YW'(i_data.start_year);
        if (i_data.start_year == '0) begin
            w_in_y = YW'(1);
        end
        w_in_m = i_data.start_month;
        if (i_data.start_month == '0) begin
            w_in_m = bdrd_pkg::MONTH_FIRST;
        end else if (i_data.start_month > bdrd_pkg::MONTH_LAST) begin
            w_in_m = bdrd_pkg::MONTH_LAST;
        end
        w_in_d = i_data.start_day;
        if (i_data.start_day == '0) begin
            w_in_d = bdrd_pkg::DAY_FIRST;
        end
        w_in_left = i_data.vacation_days;
        if (32'(i_data.vacation_days) > 32'(MAX_VACATION_DAYS)) begin
            w_in_left = SAT_LEFT;
        end
    end

    // Advance the date, the year remainders and the weekday by one day.
    always_comb begin
        s_y     = r_y;
        s_m     = r_m;
        s_d     = r_d + 1'b1;
        s_ym100 = r_ym100;
        s_yc4   = r_yc4;
        if (r_d >= w_dim) begin
            s_d = bdrd_pkg::DAY_FIRST;
            if (r_m == bdrd_pkg::MONTH_LAST) begin
                s_m = bdrd_pkg::MONTH_FIRST;
                s_y = r_y + 1'b1;
                if (r_ym100 == bdrd_pkg::Y100_LAST) begin
                    s_ym100 = '0;
                    s_yc4   = r_yc4 + 1'b1;
                end else begin
                    s_ym100 = r_ym100 + 1'b1;
                end
            end else begin
                s_m = r_m + 1'b1;
            end
        end
        s_wd = (r_wd == bdrd_pkg::WD_SAT) ? '0 : (r_wd + 1'b1);
    end

    // Operation decoder.
    always_comb begin
        n_y     = r_y;
        n_m     = r_m;
        n_d     = r_d;
        n_wd    = r_wd;
        n_left  = r_left;
        n_ym100 = r_ym100;
        n_yc4   = r_yc4;
        n_q     = r_q;
        n_acc   = r_acc;
        unique case (i_op)
            bdrd_pkg::OP_LOAD: begin
                if (i_load_en) begin
                    n_y    = w_in_y;
                    n_m    = w_in_m;
                    n_d    = w_in_d;
                    n_left = w_in_left;
                end
            end
            bdrd_pkg::OP_DIVY: begin
                n_q = QW'(w_prod100 >> bdrd_pkg::SHIFT100);
            end
            bdrd_pkg::OP_SPLIT: begin
                n_ym100 = HW'(r_y - YW'(YW'(r_q) * YW'(100)));
                n_yc4   = r_q[1:0];
            end
            bdrd_pkg::OP_CLAMP: begin
                if (r_d > w_dim) begin
                    n_d = w_dim;
                end
            end
            bdrd_pkg::OP_SUM1: begin
                n_acc = AW'(r_d) + AW'(w_yy) + AW'(w_yy >> 2);
            end
            bdrd_pkg::OP_SUM2: begin
                n_acc = r_acc - AW'(w_qq) + AW'(w_qq >> 2)
                      + AW'(bdrd_pkg::month_term(r_m));
            end
            bdrd_pkg::OP_DIV7: begin
                n_q = QW'(w_prod7 >> bdrd_pkg::SHIFT7);
            end
            bdrd_pkg::OP_REM7: begin
                n_wd = WW'(r_acc - ((AW'(r_q) << 3) - AW'(r_q)));
            end
            bdrd_pkg::OP_SKIP: begin
                if (w_weekend) begin
                    n_y = s_y; n_m = s_m; n_d = s_d; n_wd = s_wd;
                    n_ym100 = s_ym100; n_yc4 = s_yc4;
                end
            end
            bdrd_pkg::OP_COUNT: begin
                if (r_left != '0) begin
                    if (!w_weekend) begin
                        n_left = r_left - 1'b1;
                    end
                    n_y = s_y; n_m = s_m; n_d = s_d; n_wd = s_wd;
                    n_ym100 = s_ym100; n_yc4 = s_yc4;
                end
            end
            default: begin
            end
        endcase
    end

    // Working registers; they carry payload only and need no reset.
    always_ff @(posedge i_clk) begin
        r_y     <= n_y;
        r_m     <= n_m;
        r_d     <= n_d;
        r_wd    <= n_wd;
        r_left  <= n_left;
        r_ym100 <= n_ym100;
        r_yc4   <= n_yc4;
        r_q     <= n_q;
        r_acc   <= n_acc;
    end

    // Flags for the sequencer.
    assign o_flags.weekend = w_weekend;
    assign o_flags.left_nz = (r_left != '0);

    // Result word; a year past the top of the range blanks the date.
    always_comb begin
        if (r_y > bdrd_pkg::YEAR_MAX) begin
            o_result = '0;
            o_result.year_overflow = 1'b1;
        end else begin
            o_result.return_year    = bdrd_pkg::YEAR_W'(r_y);
            o_result.return_month   = r_m;
            o_result.return_day     = r_d;
            o_result.return_weekday = r_wd;
            o_result.year_overflow  = 1'b0;
        end
    end

endmodule
